/* sv/crnr_pkg.sv */
// shared constants and types for the coverage range nesting resolver
package crnr_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int POS_BITS    = 31;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic KIND_FUNC  = 1'b0;
  localparam logic KIND_BLOCK = 1'b1;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [LEVEL_W-1:0]  level_t;

  // operations on the range stack, at most one of push/pop/set_base/trim at a time
  typedef struct packed {
    logic push;
    logic pop;
    logic set_base;
    logic trim;
    pos_t value;
  } stk_cmd_t;

  typedef struct packed {
    level_t level;
    pos_t   top;
    logic   full;
  } stk_stat_t;

endpackage

/* sv/crnr_stack.sv */
// range stack: end positions in a synchronous memory, top of stack cached
module crnr_stack
  import crnr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  stk_cmd_t  cmd,
  output stk_stat_t stat
);

  pos_t   mem [STACK_DEPTH];
  pos_t   rdata;
  level_t level;
  pos_t   top_q;
  pos_t   top_next;
  logic   pop_pend;
  level_t rd_level;

  // new top after a pop sits two below the current level
  assign rd_level = level - level_t'(2);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[level[IDX_W-1:0]] <= cmd.value;
    end else if (cmd.set_base) begin
      mem[0] <= cmd.value;
    end
    rdata <= mem[rd_level[IDX_W-1:0]];
  end

  // cached top: read word right after a pop, or the value just written
  always_comb begin
    top_next = pop_pend ? rdata : top_q;
    if (cmd.push || cmd.set_base) begin
      top_next = cmd.value;
    end else if (cmd.trim && (level > level_t'(1))) begin
      top_next = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      top_q    <= '0;
      pop_pend <= 1'b0;
    end else begin
      pop_pend <= cmd.pop;
      top_q    <= top_next;
      if (cmd.push) begin
        level <= level + level_t'(1);
      end else if (cmd.pop) begin
        level <= level - level_t'(1);
      end else if (cmd.set_base) begin
        level <= level_t'(1);
      end else if (cmd.trim) begin
        if (level > level_t'(1)) begin
          level <= level_t'(1);
        end
      end
    end
  end

  // forward the read word in the cycle right after a pop
  assign stat.top   = pop_pend ? rdata : top_q;
  assign stat.level = level;
  assign stat.full  = (level == level_t'(STACK_DEPTH));

endmodule

/* sv/coverage_range_nesting_resolver_unit.sv */
// top level of the coverage range nesting resolver
//
// input words (s_axis): a function-begin word (tuser = 0) loads the function
// range, then the function's coverage blocks follow (tuser = 1), sorted by
// start ascending and end descending; tlast marks the final block.
// output words (m_axis): resolved blocks with start, closed end and count;
// tuser flags a nesting push that was dropped on a full stack, tlast marks
// the final resolved block of a run or of the function.
// a block equal in range to the held block merges into it (larger count).
// every other block is held one word, so the next start is known when the
// held one is resolved; an input word thus gives zero, one or two results.
// order: a word that only updates the held block needs no resolve; a resolve
// first pops every stack entry that ends at or before the block start, then
// closes the block. pops go one stack entry a cycle through the memory read.
// results leave through one output register; when the receiver stalls, the
// unit keeps the result and holds off further resolves until it is taken.
// reset clears the stack level, held block, function limit and output valid;
// stack memory contents are not cleared and are never read before written.
module coverage_range_nesting_resolver_unit
  import crnr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // item_start[30:0], item_end[62:31], item_count[94:63]
  input  logic        s_axis_tuser,   // kind
  input  logic        s_axis_tlast,   // last_block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // out_start[30:0], out_end[62:31], out_count[94:63]
  output logic        m_axis_tuser,   // stack_overflow
  output logic        m_axis_tlast    // out_last
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RES  = 2'b10
  } state_t;

  state_t state;

  // input word fields
  pos_t        in_start;
  logic [31:0] in_end;
  logic [31:0] in_count;
  logic        in_accept;

  // held block and latest word
  pos_t        held_start;
  logic [31:0] held_end;
  logic [31:0] held_count;
  logic        held_valid;
  pos_t        nb_start;
  logic [31:0] nb_end;
  logic [31:0] nb_count;

  // resolve control: which block, whether a next start exists, follow-up steps
  logic sel_new;
  logic has_next;
  logic f_new;
  logic f_eor;
  logic f_hold;
  logic f_fbegin;

  pos_t func_limit;
  logic past;

  // output register
  logic        out_valid;
  pos_t        out_start;
  logic [31:0] out_end;
  logic [31:0] out_count;
  logic        out_last;
  logic        out_ovf;

  stk_cmd_t  stk_cmd;
  stk_stat_t stk;

  // resolve datapath
  pos_t        b_start;
  logic [31:0] b_end;
  logic [31:0] b_count;
  logic        is_past;
  logic        can_pop;
  pos_t        close_end;
  logic [31:0] res_end;
  logic        slot;
  logic        do_pop;
  logic        finish;
  logic        do_push;
  logic        res_ovf;
  logic        in_match;
  pos_t        in_limit;
  pos_t        nb_limit;

  assign in_start = s_axis_tdata[30:0];
  assign in_end   = s_axis_tdata[62:31];
  assign in_count = s_axis_tdata[94:63];

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // negative function end clamps to zero
  assign in_limit = in_end[31] ? '0 : in_end[30:0];
  assign nb_limit = nb_end[31] ? '0 : nb_end[30:0];

  assign in_match = held_valid && (held_start == in_start) && (held_end == in_end);

  assign b_start = sel_new ? nb_start : held_start;
  assign b_end   = sel_new ? nb_end   : held_end;
  assign b_count = sel_new ? nb_count : held_count;

  // past the function end: pass through unchanged
  assign is_past = past || (b_start >= func_limit);
  // pop while the top range ends at or before this block's start
  assign can_pop = (stk.level > level_t'(1)) && (stk.top <= b_start);

  // open end closes at next start if inside the parent, else at parent end
  assign close_end = (has_next && (nb_start < stk.top)) ? nb_start : stk.top;
  assign res_end   = (!is_past && b_end[31]) ? {1'b0, close_end} : b_end;

  assign slot    = !out_valid || m_axis_tready;
  assign do_pop  = (state == S_RES) && !is_past && can_pop;
  assign finish  = (state == S_RES) && !do_pop && slot;
  assign do_push = finish && !is_past && has_next && !stk.full;
  assign res_ovf = !is_past && has_next && stk.full;

  always_comb begin
    stk_cmd          = '0;
    stk_cmd.push     = do_push;
    stk_cmd.pop      = do_pop;
    stk_cmd.value    = func_limit;
    if (do_push) begin
      stk_cmd.value = res_end[POS_BITS-1:0];
    end
    if (in_accept && (s_axis_tuser == KIND_FUNC) && !held_valid) begin
      // function begin with nothing held loads the base range at once
      stk_cmd.set_base = 1'b1;
      stk_cmd.value    = in_limit;
    end
    if (finish && !f_new && f_fbegin) begin
      stk_cmd.set_base = 1'b1;
      stk_cmd.value    = nb_limit;
    end
    if (finish && !f_new && f_eor) begin
      // end of run keeps only the function range; its end is the limit
      stk_cmd.trim = 1'b1;
    end
  end

  crnr_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (stk_cmd),
    .stat (stk)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (finish) begin
      out_start <= b_start;
      out_end   <= res_end;
      out_count <= b_count;
      out_last  <= !has_next;
      out_ovf   <= res_ovf;
    end
    if (in_accept) begin
      nb_start <= in_start;
      nb_end   <= in_end;
      nb_count <= in_count;
      if (s_axis_tuser == KIND_BLOCK) begin
        if (in_match) begin
          if (in_count > held_count) begin
            held_count <= in_count;
          end
        end else if (!held_valid && !s_axis_tlast) begin
          held_start <= in_start;
          held_end   <= in_end;
          held_count <= in_count;
        end
      end
    end
    if (finish && !f_new && f_hold) begin
      held_start <= nb_start;
      held_end   <= nb_end;
      held_count <= nb_count;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
      past       <= 1'b0;
      func_limit <= '0;
      sel_new    <= 1'b0;
      has_next   <= 1'b0;
      f_new      <= 1'b0;
      f_eor      <= 1'b0;
      f_hold     <= 1'b0;
      f_fbegin   <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            f_new    <= 1'b0;
            f_eor    <= 1'b0;
            f_hold   <= 1'b0;
            f_fbegin <= 1'b0;
            if (s_axis_tuser == KIND_FUNC) begin
              if (held_valid) begin
                // flush the held block as final, then load the function
                state    <= S_RES;
                sel_new  <= 1'b0;
                has_next <= 1'b0;
                f_fbegin <= 1'b1;
              end else begin
                func_limit <= in_limit;
                past       <= 1'b0;
              end
            end else if (in_match) begin
              if (s_axis_tlast) begin
                state    <= S_RES;
                sel_new  <= 1'b0;
                has_next <= 1'b0;
                f_eor    <= 1'b1;
              end
            end else if (held_valid) begin
              // resolve the held block against the new start
              state    <= S_RES;
              sel_new  <= 1'b0;
              has_next <= 1'b1;
              f_new    <= s_axis_tlast;
              f_eor    <= s_axis_tlast;
              f_hold   <= !s_axis_tlast;
            end else if (s_axis_tlast) begin
              state    <= S_RES;
              sel_new  <= 1'b1;
              has_next <= 1'b0;
              f_eor    <= 1'b1;
            end else begin
              held_valid <= 1'b1;
            end
          end
        end
        S_RES: begin
          if (finish) begin
            if (f_new) begin
              // second result of a final word: the new block itself
              if (is_past) begin
                past <= 1'b1;
              end
              sel_new  <= 1'b1;
              has_next <= 1'b0;
              f_new    <= 1'b0;
            end else begin
              state <= S_IDLE;
              // end of run or a new function clears the past-end mark
              if (f_eor || f_fbegin) begin
                past <= 1'b0;
              end else if (is_past) begin
                past <= 1'b1;
              end
              if (f_eor) begin
                held_valid <= 1'b0;
              end
              if (f_hold) begin
                held_valid <= 1'b1;
              end
              if (f_fbegin) begin
                func_limit <= nb_limit;
                held_valid <= 1'b0;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_count, out_end, out_start};
  assign m_axis_tuser  = out_ovf;
  assign m_axis_tlast  = out_last;

endmodule

/* tb/coverage_range_nesting_resolver_unit_tb.sv */
// testbench for the coverage range nesting resolver: directed and random words, scoreboard
module coverage_range_nesting_resolver_unit_tb;
  import crnr_pkg::*;

  localparam logic [31:0] NO_POS    = 32'hFFFF_FFFF;   // open block end, closed by the resolver
  localparam pos_t        POS_MAX   = '1;
  localparam int          RAND_WORDS = 1650;
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct packed {
    pos_t        start;
    logic [31:0] fin;
    logic [31:0] count;
  } cov_blk_t;

  typedef struct packed {
    pos_t        start;
    logic [31:0] fin;
    logic [31:0] count;
    logic        last;
    logic        ovf;
  } resolved_blk_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  always #6 clk = ~clk;

  coverage_range_nesting_resolver_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // predictor state: enclosing range ends, held block, function range
  pos_t          nest_end   [STACK_DEPTH];
  int            nest_level = 0;
  cov_blk_t      held_blk = '0;
  bit            held_ok = 1'b0;
  pos_t          func_limit = '0;
  bit            beyond_func = 1'b0;
  resolved_blk_t pending_q[$];

  int error_count = 0;
  int words_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  // appends one expected word at the tail of the queue
  function automatic void queue_word(resolved_blk_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  // closes one block and queues the resolved word
  function automatic void resolve_blk(cov_blk_t b, bit has_next, pos_t next_start);
    logic [31:0] fin = b.fin;
    bit          ovf = 1'b0;
    pos_t        parent_end;
    if (beyond_func || b.start >= func_limit) begin
      beyond_func = 1'b1;
      queue_word('{b.start, b.fin, b.count, !has_next, 1'b0});
      return;
    end
    while (nest_level > 1 && nest_end[nest_level-1] <= b.start) nest_level--;
    parent_end = (nest_level > 0) ? nest_end[nest_level-1] : func_limit;
    if (fin[31]) begin
      fin = (has_next && next_start < parent_end) ? {1'b0, next_start} : {1'b0, parent_end};
    end
    if (has_next) begin
      if (nest_level < STACK_DEPTH) begin
        nest_end[nest_level]   = fin[POS_BITS-1:0];
        nest_level++;
      end else begin
        ovf = 1'b1;
      end
    end
    queue_word('{b.start, fin, b.count, !has_next, ovf});
  endfunction

  function automatic void close_run();
    if (nest_level > 1) nest_level = 1;
    beyond_func = 1'b0;
    held_ok = 1'b0;
  endfunction

  function automatic void predict_word(logic kind, pos_t start, logic [31:0] fin,
                                       logic [31:0] count, logic last);
    cov_blk_t nb;
    nb = '{start, fin, count};
    if (kind == KIND_FUNC) begin
      if (held_ok) resolve_blk(held_blk, 1'b0, '0);
      func_limit    = fin[31] ? '0 : fin[POS_BITS-1:0];
      nest_end[0]   = func_limit;
      nest_level    = 1;
      beyond_func   = 1'b0;
      held_ok       = 1'b0;
      return;
    end
    // same range as the held block: merge, keep the larger count
    if (held_ok && held_blk.start == start && held_blk.fin == fin) begin
      if (count > held_blk.count) held_blk.count = count;
      if (last) begin
        resolve_blk(held_blk, 1'b0, '0);
        close_run();
      end
      return;
    end
    if (held_ok) resolve_blk(held_blk, 1'b1, start);
    if (last) begin
      resolve_blk(nb, 1'b0, '0);
      close_run();
      return;
    end
    held_blk = nb;
    held_ok  = 1'b1;
  endfunction

  // sends one word, in bursts with random gaps between them
  task automatic send_word(logic kind, pos_t start, logic [31:0] fin,
                           logic [31:0] count, logic last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                               : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {1'b0, count, fin, start};
    do @(posedge clk); while (!s_axis_tready);
    predict_word(kind, start, fin, count, last);
    burst_left--;
    words_sent++;
  endtask

  // hold the sender until every expected word is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_before_function();
    send_word(KIND_BLOCK, 5, 10, 7, 1'b0);
    send_word(KIND_BLOCK, 7, NO_POS, 3, 1'b1);
  endtask

  task automatic test_nesting();
    send_word(KIND_FUNC,  0, 100, 0, 1'b0);
    send_word(KIND_BLOCK, 10, 50, 3, 1'b0);
    send_word(KIND_BLOCK, 10, 50, 9, 1'b0);            // merges, larger count
    send_word(KIND_BLOCK, 12, NO_POS, 0, 1'b0);        // closed at next start
    send_word(KIND_BLOCK, 14, 30, 1, 1'b0);
    send_word(KIND_BLOCK, 20, NO_POS, 2, 1'b0);        // closed at parent end
    send_word(KIND_BLOCK, 60, NO_POS, 32'hFFFF_FFFF, 1'b0); // pops down to function
    send_word(KIND_BLOCK, 150, 160, 4, 1'b0);          // past function end
    send_word(KIND_BLOCK, 5, NO_POS, 6, 1'b1);         // still passes unchanged
  endtask

  task automatic test_special_cases();
    send_word(KIND_FUNC,  pos_t'(POS_MAX - 15), {1'b0, POS_MAX}, 0, 1'b0);
    send_word(KIND_BLOCK, pos_t'(POS_MAX - 15), {1'b0, POS_MAX}, 0, 1'b0);
    send_word(KIND_BLOCK, pos_t'(POS_MAX - 14), NO_POS, 32'hFFFF_FFFF, 1'b0);
    send_word(KIND_BLOCK, pos_t'(POS_MAX - 14), NO_POS, 5, 1'b0);
    send_word(KIND_BLOCK, pos_t'(POS_MAX - 7), {1'b0, pos_t'(POS_MAX - 6)}, 1, 1'b0);
    // merge carries last
    send_word(KIND_BLOCK, pos_t'(POS_MAX - 7), {1'b0, pos_t'(POS_MAX - 6)}, 2, 1'b1);
    send_word(KIND_BLOCK, POS_MAX, {1'b0, POS_MAX}, 32'hAAAA_AAAA, 1'b1); // new run, lone
    // negative function end: everything passes through
    send_word(KIND_FUNC,  0, NO_POS, 0, 1'b0);
    send_word(KIND_BLOCK, 0, 5, 1, 1'b0);
    send_word(KIND_BLOCK, 3, NO_POS, 2, 1'b1);
    // function begin while a block is held
    send_word(KIND_FUNC,  0, 1000, 0, 1'b0);
    send_word(KIND_BLOCK, 1, 10, 4, 1'b0);
    send_word(KIND_BLOCK, 2, NO_POS, 5, 1'b0);
    send_word(KIND_FUNC,  0, 20, 32'h5555_5555, 1'b1);
    // block end beyond its parent
    send_word(KIND_BLOCK, 1, 500, 6, 1'b0);
    send_word(KIND_BLOCK, 2, 8, 7, 1'b1);
  endtask

  task automatic test_stack_full();
    send_word(KIND_FUNC, 0, 1000, 0, 1'b0);
    for (int i = 1; i <= 70; i++) begin
      send_word(KIND_BLOCK, pos_t'(i), 32'(1000 - i), 32'(i), i == 70);
    end
  endtask

  // one function with a sorted, nested run of blocks and random content
  task automatic random_function();
    pos_t        base, pos, start, prev_start;
    logic [31:0] fin, prev_fin;
    longint      span_end;
    int          nblocks, r;
    bit          no_last;
    base = ($urandom_range(0, 4) == 0) ? pos_t'($urandom) : pos_t'($urandom_range(0, 1000));
    span_end = longint'(base) + $urandom_range(1, 400);
    if (span_end > longint'(POS_MAX)) span_end = longint'(POS_MAX);
    fin = ($urandom_range(0, 19) == 0) ? NO_POS : 32'(span_end);
    send_word(KIND_FUNC, base, fin, $urandom, 1'b0);
    nblocks = $urandom_range(1, 20);
    no_last = ($urandom_range(0, 9) == 0);
    pos = base;
    prev_start = base;
    prev_fin = '0;
    for (int k = 0; k < nblocks; k++) begin
      r = $urandom_range(0, 99);
      if (k > 0 && r < 12) begin
        start = prev_start;
        fin   = prev_fin;
      end else begin
        pos   = pos + pos_t'($urandom_range(0, 4));
        start = pos;
        if (r < 30) begin
          fin = NO_POS;
        end else if (r < 35) begin
          fin = {1'b0, pos_t'($urandom)};
        end else begin
          span_end = longint'(start) + $urandom_range(1, 40);
          if (span_end > longint'(POS_MAX)) span_end = longint'(POS_MAX);
          fin = 32'(span_end);
        end
      end
      send_word(KIND_BLOCK, start, fin,
                ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : $urandom,
                (k == nblocks - 1 && !no_last) || ($urandom_range(0, 39) == 0));
      prev_start = start;
      prev_fin = fin;
    end
  endtask

  task automatic test_random();
    int first_word;
    bit drained;
    first_word = words_sent;
    drained = 1'b0;
    while (words_sent - first_word < RAND_WORDS) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise word with every field random
        send_word(1'($urandom_range(0, 1)), pos_t'($urandom),
                  $urandom_range(0, 1) ? NO_POS : {1'b0, pos_t'($urandom)},
                  $urandom, 1'($urandom_range(0, 1)));
      end else begin
        random_function();
      end
      if (!drained && words_sent - first_word > RAND_WORDS / 2) begin
        drain_results();
        drained = 1'b1;
      end
    end
  endtask

  // receiver stall pattern, switching to a randomly chosen style as rx_tick counts up
  int rx_mode = 0;
  int rx_tick = 0;
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= (rx_tick % 4 == 0);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // compare every taken output word with the oldest prediction
  always @(posedge clk) begin : check_results
    resolved_blk_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected output word, out_start %0d", m_axis_tdata[30:0]);
        error_count++;
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[30:0] !== want.start) begin
          $error("out_start: expected %0d, got %0d", want.start, m_axis_tdata[30:0]);
          error_count++;
        end
        if (m_axis_tdata[62:31] !== want.fin) begin
          $error("out_end: expected %0d, got %0d",
                 $signed(want.fin), $signed(m_axis_tdata[62:31]));
          error_count++;
        end
        if (m_axis_tdata[94:63] !== want.count) begin
          $error("out_count: expected %0d, got %0d", want.count, m_axis_tdata[94:63]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, m_axis_tlast);
          error_count++;
        end
        if (m_axis_tuser !== want.ovf) begin
          $error("stack_overflow: expected %0d, got %0d", want.ovf, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("coverage_range_nesting_resolver_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_function();
    test_nesting();
    test_special_cases();
    test_stack_full();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("coverage_range_nesting_resolver_unit_tb: clean");
    end else begin
      $display("coverage_range_nesting_resolver_unit_tb: errors");
    end
    $finish;
  end

endmodule
